// ===== src/assert_macros.svh =====
// Assertion helpers used by the bound checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Same-cycle implication built on the macro above.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	`CHK_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== src/rgbblur_pkg.sv =====
package rgbblur_pkg;

	// Configuration port.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam int REG_SEL_BIT = 2;
	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam int FW_W = 11;
	localparam int FH_W = 16;
	localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_W-1:0] FH_RESET = 16'd768;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef logic [7:0] chan_t;
	// Index 2 is red, 1 is green, 0 is blue.
	typedef chan_t [2:0] pix_t;
	// Sum of up to three pixels of one column.
	typedef logic [9:0] vsum_t;
	typedef vsum_t [2:0] vcol_t;
	// Sum of up to nine pixels of one window.
	typedef logic [11:0] hsum_t;
	typedef hsum_t [2:0] hpix_t;
	typedef logic [3:0] count_t;

	localparam count_t CNT_1 = 4'd1;
	localparam count_t CNT_2 = 4'd2;
	localparam count_t CNT_3 = 4'd3;
	localparam count_t CNT_4 = 4'd4;
	localparam count_t CNT_6 = 4'd6;
	localparam count_t CNT_9 = 4'd9;

	// One line store entry: rows r-2 and r-1 of one column.
	typedef struct packed {
		pix_t older;
		pix_t newer;
	} lpair_t;

	// A window sum waiting for its division.
	typedef struct packed {
		hpix_t sum;
		count_t count;
		logic eof;
		logic last;
	} res_t;

	// Results handed from the sequencer to the result queue.
	typedef struct packed {
		logic [1:0] n;
		res_t first;
		res_t second;
	} push_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PIX,
		ST_FLUSH
	} state_t;

	// Truncated mean. Odd divisors use a reciprocal multiply that is exact
	// for every sum below 4096.
	function automatic chan_t mean(hsum_t s, count_t n);
		logic [23:0] p3;
		logic [23:0] p9;
		chan_t q;
		p3 = 24'(s) * 24'd2731;
		p9 = 24'(s) * 24'd3641;
		unique case (n)
			CNT_1: q = s[7:0];
			CNT_2: q = 8'(s >> 1);
			CNT_3: q = 8'(p3 >> 13);
			CNT_4: q = 8'(s >> 2);
			CNT_6: q = 8'(p3 >> 14);
			CNT_9: q = 8'(p9 >> 15);
			default: q = s[7:0];
		endcase
		return q;
	endfunction

endpackage

// ===== src/rgbblur_ifs.sv =====
interface rgbblur_pix_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source(output valid, kind, in_red, in_green, in_blue, input ready);
	modport sink(input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface rgbblur_res_if;
	logic valid;
	logic ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic end_of_frame;
	logic last_of_run;

	modport source(output valid, out_red, out_green, out_blue, end_of_frame, last_of_run,
		input ready);
	modport sink(input valid, out_red, out_green, out_blue, end_of_frame, last_of_run,
		output ready);
endinterface

// ===== src/rgb_box_blur_3x3.sv =====
// Streaming 3x3 box blur over 24-bit RGB pixels in raster order. Every output
// pixel is the truncated mean of each channel over those of its 3x3 neighbors
// that lie inside the frame (9 inside, 6 on an edge, 4 in a corner, fewer for
// frames one pixel wide or high). Output (x, y) leaves once input (x+1, y+1)
// has arrived, clipped to the frame; after the last pixel of a frame, one
// flush request per column drains the bottom row, and the flush of the last
// column carries end_of_frame and readies the block for the next frame.
// Pixels past the end of a frame and flushes before it are taken and dropped.
// A pixel request reads its column from the line store, then updates the
// store and the window. A flush request reads the one to three columns
// around its own, one after another, and then pushes its result. The next
// request is taken once the result queue drains, and results leave one per
// cycle, while the result side is ready, through an output register. The
// single read port of the line store is why these steps follow one another.
// Writing frame_width (address 0) or frame_height (address 4) restarts the
// frame; do it only with the block idle. The line store has no reset and needs no clearing pass.

module rgb_box_blur_3x3 import rgbblur_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	rgbblur_pix_if.sink pixels,
	rgbblur_res_if.source blurred,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_AW-1:0] paddr,
	input logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic pready
);

	localparam int AW = $clog2(MAX_WIDTH);
	// Wide enough for the configured width and for MAX_WIDTH itself.
	localparam int CW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

	logic [FW_W-1:0] cfg_w_q;
	logic [FH_W-1:0] cfg_h_q;
	logic [CW-1:0] fw_ext;
	logic [CW-1:0] eff_w;
	logic [CW-1:0] last_col;
	logic [AW-1:0] last_a;
	logic [FH_W-1:0] eff_h;

	logic [AW-1:0] col_q;
	logic [FH_W-1:0] row_q;
	logic [AW-1:0] flush_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] hi_q;
	logic [AW-1:0] flush_lo;
	logic [AW-1:0] flush_hi;
	// Column sums of columns c-2 and c-1 of the current row band.
	vcol_t win_prev_q;
	vcol_t win_last_q;
	hpix_t acc_q;
	count_t fcnt_q;
	pix_t pix_s1;

	state_t state_q;
	state_t state_d;

	logic cfg_wr;
	logic accept;
	logic pix_go;
	logic flush_go;
	logic row_ge1;
	logic row_ge2;
	logic tall;
	logic col_ge1;
	logic col_ge2;
	logic col_last;
	logic flush_last;
	logic flush_end;
	logic emit_a;
	logic emit_b;

	lpair_t rd_data;
	logic rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic wr_en;
	lpair_t wr_data;

	vcol_t vnew;
	hpix_t sum_a;
	hpix_t sum_b;
	hpix_t flush_sum;
	count_t cnt_a;
	count_t cnt_b;
	count_t flush_cnt;
	res_t res_a;
	res_t res_b;
	res_t res_f;
	push_t push;
	logic room;

	// Configuration. A zero size counts as one, a width beyond the store as
	// the store depth.
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_FRAME_WIDTH: prdata = CFG_DW'(cfg_w_q);
			REG_FRAME_HEIGHT: prdata = CFG_DW'(cfg_h_q);
			default: prdata = CFG_DW'(cfg_w_q);
		endcase
	end

	assign fw_ext = CW'(cfg_w_q);
	assign eff_w = (cfg_w_q == '0) ? CW'(1)
		: ((fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext);
	assign last_col = eff_w - CW'(1);
	assign last_a = last_col[AW-1:0];
	assign eff_h = (cfg_h_q == '0) ? FH_W'(1) : cfg_h_q;
	assign tall = (cfg_h_q > FH_W'(1));

	// Position flags.
	assign accept = pixels.valid && pixels.ready;
	assign pix_go = (row_q < eff_h) && (CW'(col_q) <= last_col);
	assign flush_go = (row_q >= eff_h) && (CW'(flush_q) <= last_col);
	assign row_ge1 = (row_q != '0);
	assign row_ge2 = (row_q > FH_W'(1));
	assign col_ge1 = (col_q != '0);
	assign col_ge2 = (col_q > AW'(1));
	assign col_last = (col_q == last_a);
	assign flush_last = (flush_q == last_a);
	assign flush_end = (rd_addr_q == hi_q);
	assign flush_lo = (flush_q == '0) ? '0 : flush_q - AW'(1);
	assign flush_hi = flush_last ? flush_q : flush_q + AW'(1);
	assign emit_a = row_ge1 && col_ge1;
	assign emit_b = row_ge1 && col_last;

	// Pixel update: the new column sum, then the one or two window sums that
	// it completes. The window to the left of column zero is masked off.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			vnew[j] = 10'(pix_s1[j])
				+ (row_ge1 ? 10'(rd_data.newer[j]) : 10'd0)
				+ (row_ge2 ? 10'(rd_data.older[j]) : 10'd0);
			sum_a[j] = 12'(win_last_q[j]) + 12'(vnew[j])
				+ (col_ge2 ? 12'(win_prev_q[j]) : 12'd0);
			sum_b[j] = 12'(vnew[j]) + (col_ge1 ? 12'(win_last_q[j]) : 12'd0);
			flush_sum[j] = acc_q[j] + 12'(rd_data.newer[j])
				+ (tall ? 12'(rd_data.older[j]) : 12'd0);
		end
		cnt_a = col_ge2 ? (row_ge2 ? CNT_9 : CNT_6) : (row_ge2 ? CNT_6 : CNT_4);
		cnt_b = col_ge1 ? (row_ge2 ? CNT_6 : CNT_4) : (row_ge2 ? CNT_3 : CNT_2);
		flush_cnt = fcnt_q + (tall ? CNT_2 : CNT_1);

		res_a.sum = sum_a;
		res_a.count = cnt_a;
		res_a.eof = 1'b0;
		res_a.last = !emit_b;
		res_b.sum = sum_b;
		res_b.count = cnt_b;
		res_b.eof = 1'b0;
		res_b.last = 1'b1;
		res_f.sum = flush_sum;
		res_f.count = flush_cnt;
		res_f.eof = flush_last;
		res_f.last = 1'b1;
	end

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				priority if (accept && (pixels.kind == KIND_PIXEL) && pix_go) begin
					state_d = ST_PIX;
				end else if (accept && (pixels.kind == KIND_FLUSH) && flush_go) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PIX: begin
				state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				if (flush_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer: outputs. The store is read when a request that is not dropped
	// is accepted and, for a flush, once more for each further column of the bottom row.
	always_comb begin
		pixels.ready = 1'b0;
		rd_en = 1'b0;
		mem_rd_addr = col_q;
		wr_en = 1'b0;
		push.n = 2'd0;
		push.first = res_a;
		push.second = res_b;
		unique case (state_q)
			ST_IDLE: begin
				pixels.ready = room;
				if (accept && (pixels.kind == KIND_PIXEL) && pix_go) begin
					rd_en = 1'b1;
				end else if (accept && (pixels.kind == KIND_FLUSH) && flush_go) begin
					rd_en = 1'b1;
					mem_rd_addr = flush_lo;
				end
			end
			ST_PIX: begin
				wr_en = 1'b1;
				priority if (emit_a && emit_b) begin
					push.n = 2'd2;
				end else if (emit_a) begin
					push.n = 2'd1;
				end else if (emit_b) begin
					push.n = 2'd1;
					push.first = res_b;
				end else begin
					// The top row, and column zero of a wider row, only fill the store.
					push.n = 2'd0;
				end
			end
			ST_FLUSH: begin
				if (flush_end) begin
					push.n = 2'd1;
					push.first = res_f;
				end else begin
					rd_en = 1'b1;
					mem_rd_addr = rd_addr_q + AW'(1);
				end
			end
			default: begin
				pixels.ready = 1'b0;
			end
		endcase
	end

	// The column moves down one row in the store as the new pixel lands.
	assign wr_data.older = rd_data.newer;
	assign wr_data.newer = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= FW_RESET;
			cfg_h_q <= FH_RESET;
			col_q <= '0;
			row_q <= '0;
			flush_q <= '0;
			win_prev_q <= '0;
			win_last_q <= '0;
			rd_addr_q <= '0;
			hi_q <= '0;
			acc_q <= '0;
			fcnt_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[REG_SEL_BIT] == REG_FRAME_WIDTH) begin
				cfg_w_q <= pwdata[FW_W-1:0];
			end else begin
				cfg_h_q <= pwdata[FH_W-1:0];
			end
			col_q <= '0;
			row_q <= '0;
			flush_q <= '0;
			win_prev_q <= '0;
			win_last_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (pixels.kind == KIND_FLUSH) && flush_go) begin
						rd_addr_q <= flush_lo;
						hi_q <= flush_hi;
						acc_q <= '0;
						fcnt_q <= '0;
					end
				end
				ST_PIX: begin
					win_prev_q <= win_last_q;
					win_last_q <= vnew;
					if (col_last) begin
						col_q <= '0;
						row_q <= row_q + FH_W'(1);
					end else begin
						col_q <= col_q + AW'(1);
					end
				end
				ST_FLUSH: begin
					if (flush_end) begin
						if (flush_last) begin
							// Bottom row drained: ready for a new frame.
							col_q <= '0;
							row_q <= '0;
							flush_q <= '0;
							win_prev_q <= '0;
							win_last_q <= '0;
						end else begin
							flush_q <= flush_q + AW'(1);
						end
					end else begin
						rd_addr_q <= rd_addr_q + AW'(1);
						acc_q <= flush_sum;
						fcnt_q <= flush_cnt;
					end
				end
				default: begin
					acc_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1[2] <= pixels.in_red;
			pix_s1[1] <= pixels.in_green;
			pix_s1[0] <= pixels.in_blue;
		end
	end

	rgbblur_line_mem #(
		.DEPTH(MAX_WIDTH)
	) u_line_mem (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(col_q),
		.wr_data(wr_data)
	);

	rgbblur_result_q u_result_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.blurred(blurred)
	);

endmodule

// ===== src/rgbblur_line_mem.sv =====
module rgbblur_line_mem import rgbblur_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output lpair_t rd_data,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input lpair_t wr_data
);

	// Both line stores side by side, so one access serves a whole column.
	lpair_t mem_q [DEPTH];
	lpair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/rgbblur_result_q.sv =====
module rgbblur_result_q import rgbblur_pkg::*; (
	input logic clk,
	input logic arst_n,
	input push_t push,
	output logic room,
	rgbblur_res_if.source blurred
);

	res_t q_q [2];
	logic [1:0] cnt_q;
	logic pop;
	logic out_valid_q;
	chan_t red_q;
	chan_t green_q;
	chan_t blue_q;
	logic eof_q;
	logic last_q;

	// The head is divided on its way into the output register.
	assign pop = (cnt_q != 2'd0) && (!out_valid_q || blurred.ready);
	// True when the queue is empty after this edge.
	assign room = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (push.n != 2'd0) begin
				cnt_q <= push.n;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (blurred.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			q_q[0] <= push.first;
			q_q[1] <= push.second;
		end else if (pop) begin
			q_q[0] <= q_q[1];
		end
		if (pop) begin
			red_q <= mean(q_q[0].sum[2], q_q[0].count);
			green_q <= mean(q_q[0].sum[1], q_q[0].count);
			blue_q <= mean(q_q[0].sum[0], q_q[0].count);
			eof_q <= q_q[0].eof;
			last_q <= q_q[0].last;
		end
	end

	assign blurred.valid = out_valid_q;
	assign blurred.out_red = red_q;
	assign blurred.out_green = green_q;
	assign blurred.out_blue = blue_q;
	assign blurred.end_of_frame = eof_q;
	assign blurred.last_of_run = last_q;

endmodule

// ===== src/rgbblur_checker.sv =====
`include "assert_macros.svh"

module rgbblur_checker import rgbblur_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pixels_ready,
	input logic blurred_valid,
	input logic blurred_ready,
	input logic blurred_eof,
	input logic blurred_last,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_AW-1:0] paddr,
	input logic [CFG_DW-1:0] pwdata,
	input logic [CFG_DW-1:0] prdata
);

	// A stalled result stays offered.
	`CHK_ASSERT(a_out_hold, clk, arst_n, blurred_valid && !blurred_ready |=> blurred_valid, "result dropped while stalled")

	// The frame ends only on the last result of a flush.
	`CHK_IMPLY(a_eof_last, clk, arst_n, blurred_valid && blurred_eof, blurred_last, "end_of_frame without last_of_run")

	// While the first of two results is stalled, no new request is taken.
	`CHK_IMPLY(a_no_take, clk, arst_n, blurred_valid && !blurred_ready && !blurred_last, !pixels_ready, "request taken with a result pending")

	// A width write reads back at once, cut to its field.
	`CHK_ASSERT(a_width_rb, clk, arst_n, (psel && penable && pwrite && (paddr[REG_SEL_BIT] == REG_FRAME_WIDTH)) ##1 (psel && (paddr[REG_SEL_BIT] == REG_FRAME_WIDTH)) |-> (prdata == CFG_DW'($past(pwdata[FW_W-1:0]))), "frame_width read-back mismatch")

endmodule

bind rgb_box_blur_3x3 rgbblur_checker u_rgbblur_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pixels_ready(pixels.ready),
	.blurred_valid(blurred.valid),
	.blurred_ready(blurred.ready),
	.blurred_eof(blurred.end_of_frame),
	.blurred_last(blurred.last_of_run),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);

// ===== bench/blur_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel, result and register ports. Predicts every blurred pixel
// from the accepted requests and compares it against the block's output.
module blur_checker import rgbblur_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	rgbblur_pix_if pixels,
	rgbblur_res_if blurred,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [CFG_AW-1:0] paddr,
	input logic [CFG_DW-1:0] pwdata,
	input logic [CFG_DW-1:0] prdata,
	output int blur_errors,
	output int blurs_due,
	output int live_requests
);

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic eof;
		logic last;
	} blur_t;

	logic [FW_W-1:0] frame_w;
	logic [FH_W-1:0] frame_h;
	pix_t store_up [MAX_WIDTH];
	pix_t store_mid [MAX_WIDTH];
	vcol_t win [3];
	logic [FW_W-1:0] col_pos;
	logic [FH_W-1:0] row_pos;
	logic [FW_W-1:0] flush_pos;
	blur_t pending_blurs [$];

	function automatic int unsigned span_w();
		if (frame_w == '0) begin
			return 1;
		end
		if (frame_w > MAX_WIDTH) begin
			return MAX_WIDTH;
		end
		return frame_w;
	endfunction

	function automatic int unsigned span_h();
		return (frame_h == '0) ? 1 : frame_h;
	endfunction

	function automatic blur_t blur_of(hpix_t acc, count_t n, logic eof);
		blur_t b;
		b.red = chan_t'(acc[2] / n);
		b.green = chan_t'(acc[1] / n);
		b.blue = chan_t'(acc[0] / n);
		b.eof = eof;
		b.last = 1'b0;
		return b;
	endfunction

	function automatic void flag(string msg);
		if (blur_errors < 10) begin
			$display("%s", msg);
		end
		blur_errors++;
	endfunction

	task automatic restart_frame();
		col_pos = '0;
		row_pos = '0;
		flush_pos = '0;
		foreach (win[i]) begin
			win[i] = '0;
		end
	endtask

	// Works out the blurred pixels that one request releases and queues them.
	task automatic blur_request(logic kind, pix_t px);
		int unsigned w, h, c, r, lo, hi, vrows, x;
		int k;
		hpix_t acc;
		pix_t top_p, mid_p;
		blur_t fresh [$];
		w = span_w();
		h = span_h();
		if (kind == KIND_PIXEL) begin
			c = col_pos;
			r = row_pos;
			if (r >= h || c >= w) begin
				return;
			end
			top_p = store_up[c];
			mid_p = store_mid[c];
			win[0] = win[1];
			win[1] = win[2];
			for (k = 0; k < 3; k++) begin
				win[2][k] = vsum_t'(px[k]) + (r >= 1 ? vsum_t'(mid_p[k]) : vsum_t'(0)) +
					(r >= 2 ? vsum_t'(top_p[k]) : vsum_t'(0));
			end
			store_up[c] = mid_p;
			store_mid[c] = px;
			live_requests++;
			if (r >= 1) begin
				vrows = (r >= 2) ? 3 : 2;
				if (c >= 1) begin
					for (k = 0; k < 3; k++) begin
						acc[k] = hsum_t'(win[1][k]) + hsum_t'(win[2][k]) +
							(c >= 2 ? hsum_t'(win[0][k]) : hsum_t'(0));
					end
					fresh.push_back(blur_of(acc, count_t'(vrows * (c >= 2 ? 3 : 2)), 1'b0));
				end
				// The last column also closes the window of its own column.
				if (c == w - 1) begin
					for (k = 0; k < 3; k++) begin
						acc[k] = hsum_t'(win[2][k]) + (c >= 1 ? hsum_t'(win[1][k]) : hsum_t'(0));
					end
					fresh.push_back(blur_of(acc, count_t'(vrows * (c >= 1 ? 2 : 1)), 1'b0));
				end
			end
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			col_pos = c;
			row_pos = r;
		end else begin
			if (row_pos < h || flush_pos >= w) begin
				return;
			end
			live_requests++;
			c = flush_pos;
			lo = (c >= 1) ? c - 1 : 0;
			hi = (c + 1 < w) ? c + 1 : w - 1;
			acc = '0;
			for (x = lo; x <= hi; x++) begin
				for (k = 0; k < 3; k++) begin
					acc[k] += hsum_t'(store_mid[x][k]);
					if (h >= 2) begin
						acc[k] += hsum_t'(store_up[x][k]);
					end
				end
			end
			fresh.push_back(blur_of(acc, count_t'((hi - lo + 1) * (h >= 2 ? 2 : 1)),
				c == w - 1));
			c++;
			if (c >= w) begin
				restart_frame();
			end else begin
				flush_pos = c;
			end
		end
		if (fresh.size() > 0) begin
			fresh[fresh.size() - 1].last = 1'b1;
		end
		foreach (fresh[i]) begin
			pending_blurs.push_back(fresh[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		blur_t seen, want;
		logic [CFG_DW-1:0] reg_val;
		if (!arst_n) begin
			frame_w = FW_RESET;
			frame_h = FH_RESET;
			restart_frame();
			pending_blurs.delete();
		end else begin
			if (pixels.valid && pixels.ready) begin
				blur_request(pixels.kind, {pixels.in_red, pixels.in_green, pixels.in_blue});
			end
			if (blurred.valid && blurred.ready) begin
				seen.red = blurred.out_red;
				seen.green = blurred.out_green;
				seen.blue = blurred.out_blue;
				seen.eof = blurred.end_of_frame;
				seen.last = blurred.last_of_run;
				if (pending_blurs.size() == 0) begin
					flag($sformatf("unexpected blurred pixel: r=%0d g=%0d b=%0d eof=%0b last=%0b",
						seen.red, seen.green, seen.blue, seen.eof, seen.last));
				end else begin
					want = pending_blurs.pop_front();
					if (seen.red !== want.red || seen.green !== want.green ||
						seen.blue !== want.blue || seen.eof !== want.eof ||
						seen.last !== want.last) begin
						flag($sformatf({"blurred pixel mismatch: expected r=%0d g=%0d b=%0d ",
							"eof=%0b last=%0b, got r=%0d g=%0d b=%0d eof=%0b last=%0b"},
							want.red, want.green, want.blue, want.eof, want.last,
							seen.red, seen.green, seen.blue, seen.eof, seen.last));
					end
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[REG_SEL_BIT] == REG_FRAME_WIDTH) begin
						frame_w = pwdata[FW_W-1:0];
					end else begin
						frame_h = pwdata[FH_W-1:0];
					end
					restart_frame();
				end else begin
					reg_val = (paddr[REG_SEL_BIT] == REG_FRAME_WIDTH) ?
						CFG_DW'(frame_w) : CFG_DW'(frame_h);
					if (prdata !== reg_val) begin
						flag($sformatf("register read mismatch at %0d: expected %0d, got %0d",
							paddr, reg_val, prdata));
					end
				end
			end
		end
		blurs_due = pending_blurs.size();
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Top of the bench. It only generates traffic: pixel and flush requests on
// the input channel, random back-pressure on the result channel and register
// accesses on the configuration port. All prediction and comparison lives in
// the checker instance, which hands back its error count, the number of
// blurred pixels still owed by the block, and the number of requests that the
// block actually used (pixels past the end of a frame and early flushes are
// dropped by the block and therefore not counted).
module testbench;
	import rgbblur_pkg::*;

	localparam int MAX_WIDTH = 1024;
	// Number of useful requests in the random part.
	localparam int RANDOM_REQUESTS = 1040;
	// A pixel request may yield no result, so the block may still be busy with
	// it after the last blurred pixel came out; this margin covers that before a
	// register write or the verdict.
	localparam int HOLD_OFF = 8;
	// Percentage of cycles in which each side holds back.
	localparam int IDLE_PCT = 28;
	// Limit on the whole run in ns, well above what the slowest legal run needs.
	localparam longint RUN_LIMIT_NS = 12_000_000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;
	// While high, neither side inserts idle cycles.
	logic calm;
	int blur_errors;
	int blurs_due;
	int live_requests;

	rgbblur_pix_if pix_bus();
	rgbblur_res_if res_bus();

	rgb_box_blur_3x3 #(
		.MAX_WIDTH(MAX_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_bus),
		.blurred(res_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	blur_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_bus),
		.blurred(res_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.blur_errors(blur_errors),
		.blurs_due(blurs_due),
		.live_requests(live_requests)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: a hang or a lost result ends here.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

	// The result side stalls at random, except during the calm stretch.
	always @(posedge clk) begin
		res_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Channel values biased toward the extremes, so that saturated sums and
	// all-zero windows show up often.
	function automatic chan_t pick_level();
		chan_t v;
		case ($urandom_range(7))
			0: begin
				v = 8'h00;
			end
			1: begin
				v = 8'hFF;
			end
			default: begin
				v = chan_t'($urandom);
			end
		endcase
		return v;
	endfunction

	// Presents one request after a random number of idle cycles and returns
	// at the edge that accepts it. valid is left high; the next call or a
	// drain decides whether it drops.
	task automatic send_request(logic kind, chan_t red, chan_t green, chan_t blue);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			pix_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.kind <= kind;
		pix_bus.in_red <= red;
		pix_bus.in_green <= green;
		pix_bus.in_blue <= blue;
		do begin
			@(posedge clk);
		end while (!pix_bus.ready);
	endtask

	task automatic send_random(logic kind);
		send_request(kind, pick_level(), pick_level(), pick_level());
	endtask

	// Stops the sender and waits until the block owes no more results. The
	// extra edge lets the checker account for the last accepted request.
	task automatic drain();
		pix_bus.valid <= 1'b0;
		@(posedge clk);
		wait (blurs_due == 0);
	endtask

	// One register access: setup cycle, then access cycle until pready.
	task automatic apb_access(logic wr, logic sel, logic [CFG_DW-1:0] data);
		logic [CFG_AW-1:0] addr;
		addr = '0;
		addr[REG_SEL_BIT] = sel;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Sets a new frame size with the block idle, then reads both registers
	// back so the checker can compare them.
	task automatic retune(int unsigned w, int unsigned h);
		drain();
		repeat (HOLD_OFF) @(posedge clk);
		apb_access(1'b1, REG_FRAME_WIDTH, CFG_DW'(w));
		apb_access(1'b1, REG_FRAME_HEIGHT, CFG_DW'(h));
		apb_access(1'b0, REG_FRAME_WIDTH, '0);
		apb_access(1'b0, REG_FRAME_HEIGHT, '0);
	endtask

	initial begin
		int unsigned base, frame_no, w, h, ew, eh, npix, cut, i, f;
		bit dirty, whole;

		// Every input starts at a known value, with reset asserted.
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		calm <= 1'b0;
		pix_bus.valid <= 1'b0;
		pix_bus.kind <= KIND_PIXEL;
		pix_bus.in_red <= '0;
		pix_bus.in_green <= '0;
		pix_bus.in_blue <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First the reset values of both registers, then a
		// few pixels into the default 1024 x 768 frame (row zero yields
		// nothing) and a flush that is dropped because the frame is not done.
		apb_access(1'b0, REG_FRAME_WIDTH, '0);
		apb_access(1'b0, REG_FRAME_HEIGHT, '0);
		send_request(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
		send_request(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF);
		send_request(KIND_PIXEL, 8'h00, 8'hFF, 8'h00);
		send_random(KIND_FLUSH);

		// A single-pixel frame: an early flush is dropped, the only pixel
		// completes the frame, a second pixel is dropped, the flush emits the
		// pixel itself with a count of one and end_of_frame, and a further
		// flush is dropped because the block has started a new frame.
		retune(1, 1);
		send_random(KIND_FLUSH);
		send_request(KIND_PIXEL, 8'hFF, 8'h80, 8'h01);
		send_random(KIND_PIXEL);
		send_random(KIND_FLUSH);
		send_random(KIND_FLUSH);

		// Zero width and height behave as one.
		retune(0, 0);
		send_request(KIND_PIXEL, 8'h7F, 8'hFE, 8'h00);
		send_random(KIND_FLUSH);

		// A 3 x 3 frame visits corners, edges and the full interior window,
		// with channels at both extremes.
		retune(3, 3);
		for (i = 0; i < 9; i++) begin
			send_request(KIND_PIXEL, (i % 2) ? 8'hFF : 8'h00,
				(i % 3 == 0) ? 8'hFF : 8'h00, chan_t'(i * 31));
		end
		for (f = 0; f < 3; f++) begin
			send_random(KIND_FLUSH);
		end

		// Largest settings. An all-ones width clamps to the widest row and
		// reads back as written; a few pixels go into that row. Then the
		// tallest height with a narrow row. Both frames are left unfinished
		// so that the next write restarts them.
		retune(2047, 1);
		for (i = 0; i < 24; i++) begin
			send_random(KIND_PIXEL);
		end
		retune(2, 65535);
		for (i = 0; i < 40; i++) begin
			send_random(KIND_PIXEL);
		end

		// Random part: mostly complete frames of small random size with
		// random content, often back to back without a new setting. Some
		// carry a dropped early flush or a dropped surplus pixel, and a few
		// are cut short and abandoned through a register write.
		base = live_requests;
		frame_no = 0;
		dirty = 1'b1;
		while (live_requests - base < RANDOM_REQUESTS) begin
			calm <= (frame_no >= 12 && frame_no < 24);
			if (dirty || $urandom_range(1) == 0) begin
				case ($urandom_range(19))
					0: begin
						w = 0;
					end
					1, 2: begin
						w = $urandom_range(40, 9);
					end
					default: begin
						w = $urandom_range(8, 1);
					end
				endcase
				case ($urandom_range(19))
					0: begin
						h = 0;
					end
					1, 2: begin
						h = $urandom_range(12, 7);
					end
					default: begin
						h = $urandom_range(6, 1);
					end
				endcase
				retune(w, h);
			end
			ew = (w == 0) ? 1 : w;
			eh = (h == 0) ? 1 : h;
			npix = ew * eh;
			whole = (npix == 1) || (frame_no == 5) || ($urandom_range(11) != 0);
			cut = whole ? npix : $urandom_range(npix - 1);
			for (i = 0; i < cut; i++) begin
				if ($urandom_range(24) == 0) begin
					send_random(KIND_FLUSH);
				end
				// Once, the sender holds off mid-frame until the block has
				// delivered everything it owes.
				if (frame_no == 5 && i == cut / 2) begin
					drain();
				end
				send_random(KIND_PIXEL);
			end
			if (whole) begin
				if ($urandom_range(9) == 0) begin
					send_random(KIND_PIXEL);
				end
				for (f = 0; f < ew; f++) begin
					send_random(KIND_FLUSH);
				end
			end
			dirty = !whole;
			frame_no++;
		end

		drain();
		repeat (HOLD_OFF) @(posedge clk);
		if (blur_errors == 0 && blurs_due == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
